// ----- design/starfield_star_projector_assert.svh -----
`ifndef STARFIELD_STAR_PROJECTOR_ASSERT_SVH
`define STARFIELD_STAR_PROJECTOR_ASSERT_SVH

// Property checked on every rising edge while out of reset
`define SFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("starfield star projector check failed");

// Condition at one edge implies a property at the next edge
`define SFP_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("starfield star projector sequence check failed");

`endif

// ----- design/sfp_pkg.sv -----
package sfp_pkg;

  // Star table
  localparam int STAR_COUNT = 1024;
  localparam int IDX_W      = $clog2(STAR_COUNT);

  // Geometry and spawn constants
  localparam int CENTER_X    = 320;
  localparam int CENTER_Y    = 240;
  localparam int SPAWN_W     = 640;
  localparam int SPAWN_H     = 480;
  localparam int SPAWN_DEPTH = 500;
  localparam int DIM_STEP    = 100;

  // Divider sizes
  localparam int PROD_W = 20;
  localparam int DVSR_W = 9;
  localparam int STEP_W = 5;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DIST   = 3'd0,
    CFG_SPEED  = 3'd1,
    CFG_ACTIVE = 3'd2,
    CFG_COLOR  = 3'd3,
    CFG_WIDTH  = 3'd4,
    CFG_HEIGHT = 3'd5
  } cfg_idx_e;

  // Input commands
  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_STAR  = 1'b1
  } cmd_e;

  // One star table entry
  typedef struct packed {
    logic              alive;
    logic [9:0]        depth;
    logic signed [9:0] y;
    logic signed [10:0] x;
  } star_entry_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- design/starfield_star_projector.sv -----
// Channel  Direction  Fields (low bit first)
// s_axis   in         tuser: command; tdata: star_index, seed_x, seed_y
// m_axis   out        tuser: pixel_valid, star_died;
//                     tdata: pixel_x, pixel_y, pixel_color, stars_alive
// cfg      in         write enable, register index, write data
//
// Reset starts a clearing pass over the star table with s_axis_tready low.
// A star transfer uses the shared bit-serial divider (two 20-step divisions
// for the projection, three 8-step ones for the colour of a visible star).
// One result waits in the output register; a new input is taken while it
// stalls.
module starfield_star_projector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // star_index[9:0], seed_x[21:10], seed_y[33:22]
  input  logic [0:0]  s_axis_tuser,  // command[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // pixel_x, pixel_y, pixel_color, stars_alive
  output logic [1:0]  m_axis_tuser,  // pixel_valid[0], star_died[1]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [23:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_MUL, S_DSTART, S_DWAIT, S_UPDATE, S_DONE
  } state_e;

  typedef enum logic [2:0] {OP_X, OP_Y, OP_R, OP_G, OP_B} op_e;

  localparam int IW = sfp_pkg::IDX_W;

  // Configuration registers
  logic [9:0]  dist_q;
  logic [4:0]  speed_q;
  logic [10:0] active_q;
  logic [23:0] color_q;
  logic [12:0] fw_q;
  logic [12:0] fh_q;

  state_e              state_q;
  op_e                 op_q;
  logic [IW-1:0]       clr_q;
  logic [IW-1:0]       idx_q;
  logic signed [11:0]  seedx_q;
  logic signed [11:0]  seedy_q;
  logic                respawn_q;
  logic [10:0]         live_q;
  logic signed [10:0]  x_q;
  logic signed [9:0]   y_q;
  logic [9:0]          z_q;
  logic [2:0]          mod_q;
  logic [19:0]         prod_q;
  logic [19:0]         qx_q;
  logic [19:0]         qy_q;
  logic                pv_q;
  logic [11:0]         px_q;
  logic [11:0]         py_q;
  logic [23:0]         col_q;
  logic                died_q;
  logic                m_tvalid_q;
  logic [63:0]         m_tdata_q;
  logic [1:0]          m_tuser_q;

  sfp_pkg::star_entry_t mem_q [sfp_pkg::STAR_COUNT];
  sfp_pkg::star_entry_t rd_q;
  sfp_pkg::star_entry_t wr_entry;

  sfp_pkg::div_req_t           div_req;
  sfp_pkg::div_rsp_t           div_rsp;
  logic [sfp_pkg::PROD_W-1:0]  div_dividend;
  logic [sfp_pkg::DVSR_W-1:0]  div_divisor;

  logic                in_xfer;
  logic                out_free;
  logic signed [10:0]  spawn_x;
  logic signed [9:0]   spawn_y;
  logic [9:0]          mag;
  logic [19:0]         prod_c;
  logic signed [21:0]  offx;
  logic signed [21:0]  offy;
  logic signed [21:0]  sx_c;
  logic signed [21:0]  sy_c;
  logic signed [11:0]  znew_c;
  logic                die_c;
  logic [2:0]          mod_c;

  // Unsigned remainder by a constant through at most three subtractions
  function automatic logic [11:0] sfp_rem(logic [11:0] m, logic [11:0] d);
    logic [11:0] r;
    r = m;
    if (r >= 12'(3 * d)) r = 12'(r - 3 * d);
    if (r >= 12'(2 * d)) r = 12'(r - 2 * d);
    if (r >= d) r = 12'(r - d);
    return r;
  endfunction

  function automatic logic [11:0] sfp_abs12(logic signed [11:0] s);
    return s[11] ? 12'(~s + 12'sd1) : 12'(s);
  endfunction

  always_comb begin
    logic [11:0] rx;
    logic [11:0] ry;
    rx = sfp_rem(sfp_abs12(seedx_q), 12'(sfp_pkg::SPAWN_W));
    ry = sfp_rem(sfp_abs12(seedy_q), 12'(sfp_pkg::SPAWN_H));
    if (ry >= 12'(sfp_pkg::SPAWN_H)) ry = 12'(ry - 12'(sfp_pkg::SPAWN_H));
    spawn_x = seedx_q[11] ? 11'(~{1'b0, rx[9:0]} + 11'd1) : {1'b0, rx[9:0]};
    spawn_y = seedy_q[11] ? 10'(~{1'b0, ry[8:0]} + 10'd1) : {1'b0, ry[8:0]};
  end

  // Magnitude of the coordinate for the shared multiplier
  always_comb begin
    if (op_q == OP_X) begin
      mag = x_q[10] ? 10'(~x_q + 11'sd1) : x_q[9:0];
    end else begin
      mag = y_q[9] ? 10'(~y_q + 10'sd1) : y_q;
    end
  end
  assign prod_c = {10'd0, dist_q} * {10'd0, mag};

  // Projection, depth step and visibility
  assign offx   = x_q[10] ? -$signed({2'b00, qx_q}) : $signed({2'b00, qx_q});
  assign offy   = y_q[9]  ? -$signed({2'b00, qy_q}) : $signed({2'b00, qy_q});
  assign sx_c   = 22'(sfp_pkg::CENTER_X) + offx;
  assign sy_c   = 22'(sfp_pkg::CENTER_Y) + offy;
  assign znew_c = $signed({2'b00, z_q}) - $signed({7'd0, speed_q});
  assign die_c  = sx_c < 0 || sy_c < 0 ||
                  sx_c >= $signed({9'd0, fw_q}) || sy_c >= $signed({9'd0, fh_q}) ||
                  znew_c <= 0;

  // Dimming factor: depth over the dim step, at least one
  always_comb begin
    if (znew_c >= 12'sd500) mod_c = 3'd5;
    else if (znew_c >= 12'sd400) mod_c = 3'd4;
    else if (znew_c >= 12'sd300) mod_c = 3'd3;
    else if (znew_c >= 12'(2 * sfp_pkg::DIM_STEP)) mod_c = 3'd2;
    else mod_c = 3'd1;
  end

  assign wr_entry = '{alive: ~die_c, depth: znew_c[9:0], y: y_q, x: x_q};

  // Divider operands
  always_comb begin
    div_req.start = (state_q == S_DSTART);
    case (op_q)
      OP_X, OP_Y: begin
        div_req.steps = sfp_pkg::STEP_W'(sfp_pkg::PROD_W);
        div_dividend  = prod_q;
        div_divisor   = z_q[8:0];
      end
      OP_R: begin
        div_req.steps = sfp_pkg::STEP_W'(8);
        div_dividend  = {color_q[7:0], 12'd0};
        div_divisor   = {6'd0, mod_q};
      end
      OP_G: begin
        div_req.steps = sfp_pkg::STEP_W'(8);
        div_dividend  = {color_q[15:8], 12'd0};
        div_divisor   = {6'd0, mod_q};
      end
      OP_B: begin
        div_req.steps = sfp_pkg::STEP_W'(8);
        div_dividend  = {color_q[23:16], 12'd0};
        div_divisor   = {6'd0, mod_q};
      end
      default: begin
        div_req.steps = sfp_pkg::STEP_W'(8);
        div_dividend  = '0;
        div_divisor   = '0;
      end
    endcase
  end

  sfp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .rsp_o      (div_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q   <= 10'd256;
      speed_q  <= '0;
      active_q <= '0;
      color_q  <= '0;
      fw_q     <= 13'd640;
      fh_q     <= 13'd480;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sfp_pkg::CFG_DIST:   dist_q   <= cfg_wdata_i[9:0];
        sfp_pkg::CFG_SPEED:  speed_q  <= cfg_wdata_i[4:0];
        sfp_pkg::CFG_ACTIVE: active_q <= cfg_wdata_i[10:0];
        sfp_pkg::CFG_COLOR:  color_q  <= cfg_wdata_i;
        sfp_pkg::CFG_WIDTH:  fw_q     <= cfg_wdata_i[12:0];
        sfp_pkg::CFG_HEIGHT: fh_q     <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  // Star table: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      mem_q[clr_q] <= '0;
    end else if (state_q == S_UPDATE) begin
      mem_q[idx_q] <= wr_entry;
    end
    if (in_xfer) begin
      rd_q <= mem_q[s_axis_tdata[IW-1:0]];
    end
  end

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_tvalid_q || m_axis_tready;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      op_q       <= OP_X;
      clr_q      <= '0;
      respawn_q  <= 1'b0;
      live_q     <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      m_tuser_q  <= '0;
      idx_q      <= '0;
      seedx_q    <= '0;
      seedy_q    <= '0;
      x_q        <= '0;
      y_q        <= '0;
      z_q        <= '0;
      mod_q      <= '0;
      prod_q     <= '0;
      qx_q       <= '0;
      qy_q       <= '0;
      pv_q       <= 1'b0;
      px_q       <= '0;
      py_q       <= '0;
      col_q      <= '0;
      died_q     <= 1'b0;
    end else begin
      // Drop the output once it is taken, unless a new result replaces it
      if (m_tvalid_q && m_axis_tready && state_q != S_DONE) m_tvalid_q <= 1'b0;

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IW'(1);
          if (clr_q == IW'(sfp_pkg::STAR_COUNT - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_xfer) begin
            idx_q   <= s_axis_tdata[IW-1:0];
            seedx_q <= s_axis_tdata[21:10];
            seedy_q <= s_axis_tdata[33:22];
            pv_q    <= 1'b0;
            px_q    <= '0;
            py_q    <= '0;
            col_q   <= '0;
            died_q  <= 1'b0;
            if (s_axis_tuser[0] == sfp_pkg::CMD_FRAME) begin
              respawn_q <= live_q < active_q;
              state_q   <= S_DONE;
            end else begin
              state_q <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (!rd_q.alive && !respawn_q) begin
            state_q <= S_DONE;
          end else begin
            if (rd_q.alive) begin
              x_q <= rd_q.x;
              y_q <= rd_q.y;
              z_q <= rd_q.depth;
            end else begin
              x_q <= spawn_x;
              y_q <= spawn_y;
              z_q <= 10'(sfp_pkg::SPAWN_DEPTH);
              if (live_q != 11'h7FF) live_q <= live_q + 11'd1;
            end
            op_q    <= OP_X;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= prod_c;
          state_q <= S_DSTART;
        end
        S_DSTART: begin
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            case (op_q)
              OP_X: begin
                qx_q    <= div_rsp.quot;
                op_q    <= OP_Y;
                state_q <= S_MUL;
              end
              OP_Y: begin
                qy_q    <= div_rsp.quot;
                state_q <= S_UPDATE;
              end
              OP_R: begin
                col_q[7:0] <= div_rsp.quot[7:0];
                op_q       <= OP_G;
                state_q    <= S_DSTART;
              end
              OP_G: begin
                col_q[15:8] <= div_rsp.quot[7:0];
                op_q        <= OP_B;
                state_q     <= S_DSTART;
              end
              default: begin
                col_q[23:16] <= div_rsp.quot[7:0];
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_UPDATE: begin
          if (die_c) begin
            died_q  <= 1'b1;
            if (live_q != 11'd0) live_q <= live_q - 11'd1;
            state_q <= S_DONE;
          end else begin
            pv_q    <= 1'b1;
            px_q    <= sx_c[11:0];
            py_q    <= sy_c[11:0];
            mod_q   <= mod_c;
            op_q    <= OP_R;
            state_q <= S_DSTART;
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= {5'd0, live_q, col_q, py_q, px_q};
            m_tuser_q  <= {died_q, pv_q};
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

// ----- design/sfp_div.sv -----
module sfp_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sfp_pkg::div_req_t         req_i,
  input  logic [sfp_pkg::PROD_W-1:0] dividend_i,
  input  logic [sfp_pkg::DVSR_W-1:0] divisor_i,
  output sfp_pkg::div_rsp_t         rsp_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [sfp_pkg::STEP_W-1:0]  cnt_q;
  logic [sfp_pkg::PROD_W-1:0]  quot_q;
  logic [sfp_pkg::DVSR_W-1:0]  rem_q;
  logic [sfp_pkg::DVSR_W-1:0]  dvsr_q;
  logic [sfp_pkg::DVSR_W:0]    trial;
  logic                        fits;
  logic [sfp_pkg::DVSR_W-1:0]  rem_d;

  // One restoring step: shift in the next dividend bit, subtract when it fits
  assign trial = {rem_q, quot_q[sfp_pkg::PROD_W-1]};
  assign fits  = trial >= {1'b0, dvsr_q};
  assign rem_d = fits ? sfp_pkg::DVSR_W'(trial - {1'b0, dvsr_q})
                      : trial[sfp_pkg::DVSR_W-1:0];

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - sfp_pkg::STEP_W'(1);
      if (cnt_q == sfp_pkg::STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Quotient and remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[sfp_pkg::PROD_W-2:0], fits};
      rem_q  <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ----- design/sfp_checker.sv -----
`include "starfield_star_projector_assert.svh"

module sfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // Stalled result holds
  `SFP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // One item at a time: no input right after a transfer
  `SFP_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A pixel and a death never come together
  `SFP_ASSERT(a_pixel_or_death, !(m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1]))

  // No pixel means zero pixel fields
  `SFP_ASSERT(a_zero_fields, !(m_axis_tvalid && !m_axis_tuser[0]) || m_axis_tdata[47:0] == 48'd0)

endmodule

bind starfield_star_projector sfp_checker u_sfp_checker (.*);
